>>> rtl/bfms_pkg.sv
// Package for the byte frequency minimum select block.
// Holds the request kind codes and the controller state type.
// No dependencies.
package bfms_pkg;

   // Request kinds carried on req_tuser.
   localparam logic REQ_ADD   = 1'b0;
   localparam logic REQ_FETCH = 1'b1;

   // Controller states, one-hot.
   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_RUN    = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

endpackage

>>> rtl/bfms_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// A read at the address written in the same cycle returns the old data.
// No dependencies.
module bfms_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bfms_min_scan.sv
// Running minimum tracker for the histogram scan.
// Keeps the smallest nonzero count seen so far; later bins win ties.
// No dependencies.
module bfms_min_scan #(
   parameter int IDX_W = 8,
   parameter int CNT_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             in_vld,
   input  logic [IDX_W-1:0] in_idx,
   input  logic [CNT_W-1:0] in_cnt,
   output logic             found,
   output logic [IDX_W-1:0] best_idx,
   output logic [CNT_W-1:0] best_cnt
);

   logic             found_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic [CNT_W-1:0] best_cnt_ff;
   logic             take;

   // A bin replaces the best one if it is nonzero and not larger.
   assign take = in_vld && (in_cnt != '0) && (!found_ff || (in_cnt <= best_cnt_ff));

   // Found flag is control state and is cleared at the start of each scan.
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (start) begin
         found_ff <= 1'b0;
      end else if (take) begin
         found_ff <= 1'b1;
      end
   end

   // Best symbol and count.
   always_ff @(posedge clock) begin
      if (take) begin
         best_idx_ff <= in_idx;
         best_cnt_ff <= in_cnt;
      end
   end

   assign found    = found_ff;
   assign best_idx = best_idx_ff;
   assign best_cnt = best_cnt_ff;

endmodule

>>> rtl/byte_frequency_min_select.sv
// Byte frequency histogram with least-frequent-first readout.
// Add requests: one transfer per cycle while in ST_RUN; read-modify-write through a RAM with a
// registered read port, with forwarding. Fetch requests: a scan of bins 1 to NUM_SYMBOLS-1, one
// RAM read per cycle, then ST_DRAIN; the result is registered on leaving ST_FINISH, which holds
// while an earlier result still waits for rsp_tready; the next request is taken back in ST_RUN.
// Reset: synchronous; a clearing pass then zeroes all NUM_SYMBOLS bins before req_tready rises.
module byte_frequency_min_select #(
   parameter int NUM_SYMBOLS = 256,
   parameter int COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] symbol
   input  logic        req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] symbol_out, [23:8] count_out
   output logic        rsp_tuser    // [0] done_res
);

   import bfms_pkg::*;

   localparam int IDX_W = $clog2(NUM_SYMBOLS);
   localparam logic [IDX_W-1:0]       LAST_IDX  = IDX_W'(NUM_SYMBOLS - 1);
   localparam logic [IDX_W-1:0]       FIRST_IDX = IDX_W'(1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   state_type state_ff, state_in;

   logic [IDX_W-1:0]       clr_addr_ff, clr_addr_in;
   logic [IDX_W-1:0]       scan_addr_ff, scan_addr_in;
   logic                   s1_vld_ff, s1_vld_in;
   logic [IDX_W-1:0]       s1_addr_ff;
   logic                   fwd_vld_ff;
   logic [IDX_W-1:0]       fwd_addr_ff;
   logic [COUNT_WIDTH-1:0] fwd_data_ff;
   logic                   scan_vld_ff;
   logic [IDX_W-1:0]       scan_idx_ff;
   logic                   rsp_vld_ff, rsp_vld_in;
   logic [7:0]             rsp_sym_ff;
   logic [15:0]            rsp_cnt_ff;
   logic                   rsp_done_ff;

   logic                   req_xfer;
   logic                   fetch_xfer;
   logic                   add_ok;
   logic [31:0]            sym_ext;
   logic [IDX_W-1:0]       req_addr;
   logic                   issue;
   logic                   finish_go;

   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [COUNT_WIDTH-1:0] wr_data;
   logic [IDX_W-1:0]       rd_addr;
   logic [COUNT_WIDTH-1:0] rd_data;
   logic [COUNT_WIDTH-1:0] cur_cnt;
   logic [COUNT_WIDTH-1:0] inc_cnt;

   logic                   found;
   logic [IDX_W-1:0]       best_idx;
   logic [COUNT_WIDTH-1:0] best_cnt;
   logic [31:0]            best_idx_ext;
   logic [31:0]            best_cnt_ext;

   // Request decode.
   assign req_tready = (state_ff == ST_RUN);
   assign req_xfer   = req_tvalid && req_tready;
   assign fetch_xfer = req_xfer && (req_tuser == REQ_FETCH);
   assign sym_ext    = 32'(req_tdata);
   assign req_addr   = sym_ext[IDX_W-1:0];
   assign add_ok     = req_xfer && (req_tuser == REQ_ADD) && (sym_ext != 32'd0)
                       && (sym_ext < 32'(NUM_SYMBOLS));

   // Scan reads wait until a pending add has written back.
   assign issue     = (state_ff == ST_SCAN) && !s1_vld_ff;
   assign finish_go = !rsp_vld_ff || rsp_tready;

   // Histogram memory.
   assign rd_addr = (state_ff == ST_SCAN) ? scan_addr_ff : req_addr;

   bfms_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (NUM_SYMBOLS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Increment with forwarding of the write made at the previous edge.
   assign cur_cnt = (fwd_vld_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : rd_data;
   assign inc_cnt = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;

   // Write port arbitration: clearing pass, bin clear after a fetch, add writeback.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = s1_addr_ff;
      wr_data = inc_cnt;
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else if ((state_ff == ST_FINISH) && finish_go && found) begin
         wr_en   = 1'b1;
         wr_addr = best_idx;
         wr_data = '0;
      end else if (s1_vld_ff) begin
         wr_en   = 1'b1;
      end
   end

   // Minimum tracker fed by the scan reads.
   bfms_min_scan #(
      .IDX_W (IDX_W),
      .CNT_W (COUNT_WIDTH)
   ) u_min_scan (
      .clock    (clock),
      .reset    (reset),
      .start    (fetch_xfer),
      .in_vld   (scan_vld_ff),
      .in_idx   (scan_idx_ff),
      .in_cnt   (rd_data),
      .found    (found),
      .best_idx (best_idx),
      .best_cnt (best_cnt)
   );

   // Controller next state.
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      scan_addr_in = scan_addr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_IDX) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (fetch_xfer) begin
               state_in     = ST_SCAN;
               scan_addr_in = FIRST_IDX;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               scan_addr_in = scan_addr_ff + 1'b1;
               if (scan_addr_ff == LAST_IDX) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (finish_go) begin
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Result register next valid.
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if ((state_ff == ST_FINISH) && finish_go) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   assign s1_vld_in = add_ok;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         s1_vld_ff   <= 1'b0;
         fwd_vld_ff  <= 1'b0;
         scan_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         s1_vld_ff   <= s1_vld_in;
         fwd_vld_ff  <= wr_en;
         scan_vld_ff <= issue;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // Payload registers of the pipeline and the scan.
   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      s1_addr_ff   <= req_addr;
      fwd_addr_ff  <= wr_addr;
      fwd_data_ff  <= wr_data;
      scan_idx_ff  <= scan_addr_ff;
   end

   // Result payload, count saturated to 16 bits.
   assign best_idx_ext = 32'(best_idx);
   assign best_cnt_ext = 32'(best_cnt);

   always_ff @(posedge clock) begin
      if ((state_ff == ST_FINISH) && finish_go) begin
         if (found) begin
            rsp_sym_ff  <= best_idx_ext[7:0];
            rsp_cnt_ff  <= (best_cnt_ext > 32'h0000_FFFF) ? 16'hFFFF : best_cnt_ext[15:0];
            rsp_done_ff <= 1'b0;
         end else begin
            rsp_sym_ff  <= 8'd0;
            rsp_cnt_ff  <= 16'd0;
            rsp_done_ff <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {rsp_cnt_ff, rsp_sym_ff};
   assign rsp_tuser  = rsp_done_ff;

endmodule
